// ===== rtl/core/msq_pkg.sv =====
package msq_pkg;

	// Operation codes carried by a request
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_START = 2'd2,
		OP_TONE  = 2'd3
	} op_t;

	// One stored note: duration in the upper half, frequency in the lower half
	typedef struct packed {
		logic [15:0] dur;
		logic [15:0] freq;
	} note_t;

	localparam int unsigned NOTE_W = $bits(note_t);

	typedef struct packed {
		op_t         operation;
		logic [2:0]  note_slot;
		logic [15:0] note_freq;
		logic [15:0] note_duration;
		logic [3:0]  melody_length;
	} item_t;

	typedef struct packed {
		logic [15:0] tone_freq;
		logic        melody_playing;
		logic        tone_timed;
		logic [2:0]  current_note;
	} result_t;

	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

endpackage

// ===== rtl/core/msq_ram.sv =====
module msq_ram import msq_pkg::*; #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/melody_note_sequencer_top.sv =====
// Channel  | Direction | Handshake                   | Payload
// item     | in        | item_valid / item_ready     | item_t   (operation, slot, freq, dur, len)
// result   | out       | result_valid / result_ready | result_t (state after the request)
//
// Every request is executed in the cycle it is accepted; one per cycle sustained
// while result_ready keeps the skid entry empty. The note store is a one-port-read
// RAM; the note after the current one is prefetched, and a write to that slot is
// bypassed around the RAM. Results go to an output register with one skid entry;
// item_ready drops only when both hold a result. Reset clears all control state;
// the store holds whatever was last written.
module melody_note_sequencer_top import msq_pkg::*; #(
	parameter int unsigned MAX_NOTES = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int unsigned IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int unsigned CW = $clog2(MAX_NOTES + 1);

	// Sequencer state
	logic [CW-1:0] count_q,   count_d;
	logic [IW-1:0] idx_q,     idx_d;
	logic [15:0]   elapsed_q, elapsed_d;
	logic          melody_q,  melody_d;
	logic          tone_q,    tone_d;
	logic [15:0]   remain_q,  remain_d;
	logic [15:0]   drive_q,   drive_d;
	logic [15:0]   cur_dur_q, cur_dur_d;
	note_t         slot0_q;

	// Store access
	logic          push;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	note_t         wr_note;
	logic [IW-1:0] rd_addr;
	logic [CW-1:0] rd_next;
	logic [NOTE_W-1:0] rd_data;
	logic          byp_hit_q;
	note_t         byp_note_q;
	note_t         nxt_note;

	// Tick helpers
	logic [CW-1:0] idx_inc;
	logic [15:0]   el_inc;
	logic [15:0]   rem_dec;
	logic [CW-1:0] len_sat;

	// Output queue
	result_t res;
	result_t out_q, skid_q;
	logic    out_valid_q, skid_valid_q;

	assign item_ready   = !skid_valid_q;
	assign push         = item_valid && item_ready;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// Note after the current one, bypassing a write from the previous cycle
	assign nxt_note = byp_hit_q ? byp_note_q : note_t'(rd_data);

	assign wr_note = '{dur: item.note_duration, freq: item.note_freq};
	assign wr_addr = IW'(item.note_slot);
	assign wr_en   = push && (item.operation == OP_LOAD) && (32'(item.note_slot) < MAX_NOTES);

	assign idx_inc = CW'(idx_q) + CW'(1);
	assign el_inc  = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 16'd1 : elapsed_q;
	assign rem_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : remain_q;
	assign len_sat = (32'(item.melody_length) > MAX_NOTES) ? CW'(MAX_NOTES)
	                                                       : CW'(item.melody_length);

	// Execute the accepted request
	always_comb begin
		count_d   = count_q;
		idx_d     = idx_q;
		elapsed_d = elapsed_q;
		melody_d  = melody_q;
		tone_d    = tone_q;
		remain_d  = remain_q;
		drive_d   = drive_q;
		cur_dur_d = cur_dur_q;
		if (push) begin
			case (item.operation)
				OP_TICK: begin
					remain_d = rem_dec;
					if (melody_q) begin
						elapsed_d = el_inc;
						if (el_inc >= cur_dur_q) begin
							if (idx_inc >= count_q) begin
								melody_d = 1'b0;
								idx_d    = '0;
								drive_d  = '0;
							end else begin
								idx_d     = IW'(idx_inc);
								drive_d   = nxt_note.freq;
								cur_dur_d = nxt_note.dur;
								elapsed_d = '0;
							end
						end
					end else if (tone_q && rem_dec == 16'd0) begin
						drive_d = '0;
						tone_d  = 1'b0;
					end
				end
				OP_LOAD: begin
					// Keep the cached duration of the current note coherent
					if (wr_en && wr_addr == idx_q) begin
						cur_dur_d = item.note_duration;
					end
				end
				OP_START: begin
					idx_d     = '0;
					elapsed_d = '0;
					count_d   = len_sat;
					if (len_sat == '0) begin
						melody_d = 1'b0;
						drive_d  = '0;
					end else begin
						melody_d  = 1'b1;
						drive_d   = slot0_q.freq;
						cur_dur_d = slot0_q.dur;
					end
				end
				OP_TONE: begin
					drive_d  = item.note_freq;
					tone_d   = 1'b1;
					remain_d = item.note_duration;
				end
				default: begin
					drive_d = drive_q;
				end
			endcase
		end
	end

	// Prefetch the note after the next-state index
	always_comb begin
		rd_next = CW'(idx_d) + CW'(1);
		if (32'(rd_next) >= MAX_NOTES) begin
			rd_addr = '0;
		end else begin
			rd_addr = IW'(rd_next);
		end
	end

	assign res = '{
		tone_freq:      drive_d,
		melody_playing: melody_d,
		tone_timed:     tone_d,
		current_note:   melody_d ? 3'(idx_d) : 3'd0
	};

	msq_ram #(
		.WIDTH (NOTE_W),
		.DEPTH (MAX_NOTES)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_note),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Hold sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			idx_q     <= '0;
			elapsed_q <= '0;
			melody_q  <= 1'b0;
			tone_q    <= 1'b0;
			remain_q  <= '0;
			drive_q   <= '0;
			byp_hit_q <= 1'b0;
		end else begin
			count_q   <= count_d;
			idx_q     <= idx_d;
			elapsed_q <= elapsed_d;
			melody_q  <= melody_d;
			tone_q    <= tone_d;
			remain_q  <= remain_d;
			drive_q   <= drive_d;
			byp_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	// Cached note data, valid only once written
	always_ff @(posedge clk) begin
		cur_dur_q  <= cur_dur_d;
		byp_note_q <= wr_note;
		if (wr_en && wr_addr == '0) begin
			slot0_q <= wr_note;
		end
	end

	// Output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || result_ready) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || result_ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

endmodule
